[hw/rtl/assert_macros.svh]
// assertion macros used by the encapsulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on aclk, held off while aresetn is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication check on aclk, held off while aresetn is low
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

[hw/rtl/ipip_pkg.sv]
// constants and codes for the ipv4-in-ipv4 encapsulator
package ipip_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned POS_W = 16;
    localparam int unsigned HOLD_BYTES = 18;
    localparam int unsigned HOLD_IDX_W = $clog2(HOLD_BYTES);

    // frame handling modes
    localparam logic [1:0] MODE_COLLECT = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_ENCAP   = 2'd2;

    // verdict codes carried on the last item of a frame
    localparam logic [1:0] VERDICT_TX   = 2'd0;
    localparam logic [1:0] VERDICT_PASS = 2'd1;
    localparam logic [1:0] VERDICT_DROP = 2'd2;

    // header bursts
    localparam int unsigned BURST_W = 6;
    localparam logic [BURST_W-1:0] PASS_BURST_LAST  = BURST_W'(13);
    localparam logic [BURST_W-1:0] ENCAP_BURST_LAST = BURST_W'(37);

    // frame positions of interest
    localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_HOLD_END = POS_W'(17);
    localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(23);

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // fixed outer header words summed: 0x4500 + 0x0804 + four 0xffff address words
    localparam logic [18:0] CSUM_BASE = 19'h44D00;

endpackage

[hw/rtl/ipv4_in_ipv4_encapsulator_unit.sv]
// ipv4-in-ipv4 encapsulator: byte stream in, encapsulated or passed frame out
// one frame byte per item on both sides. a frame whose ethertype is not ipv4 leaves
// unchanged with verdict pass; an ipv4 frame gets a broadcast ethernet header (old
// destination as source) and an outer ipv4 header (protocol 4, ttl 8, all-ones
// addresses, total length = inner + 20, checksum) ahead of the inner packet, verdict
// transmit, or drop if the frame is too short. a frame ending before anything left
// yields one bare drop item. steady rate is one item per cycle while the output is taken;
// the header burst is played from a byte counter out of the held first 18 bytes, so
// input stalls while the burst plays, after the 18th byte of an ipv4 frame and after
// the 14th byte of any other frame. an input register and an output register part
// the two sides, so an item is taken while a result waits downstream.
module ipv4_in_ipv4_encapsulator_unit
    import ipip_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte [7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast,
    output logic [1:0] m_tuser    // verdict [1:0]
);

`include "assert_macros.svh"

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       proto_reg, proto_next;
    logic [7:0]       hold_reg [HOLD_BYTES];

    // header burst sequencer
    logic               burst_active_reg, burst_active_next;
    logic               burst_encap_reg, burst_encap_next;  // 0: plain 14-byte replay
    logic               burst_fin_reg, burst_fin_next;      // replay ends the frame
    logic [BURST_W-1:0] burst_cnt_reg, burst_cnt_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] out_verdict_reg;

    logic       out_free;
    logic       in_consume;
    logic       burst_emit;
    logic       hold_wr;
    logic       out_load;
    logic [7:0] ob;
    logic       ol;
    logic [1:0] ov;

    logic [POS_W-1:0]      pos_adv;
    logic [7:0]            proto_now;
    logic [BURST_W-1:0]    burst_end;
    logic [BURST_W-1:0]    hold_sel;
    logic [HOLD_IDX_W-1:0] hold_idx;
    logic [7:0]            hold_byte;
    logic [7:0]            burst_byte;

    // outer header length and checksum
    logic [15:0] total_len;
    logic [18:0] csum_sum;
    logic [16:0] csum_fold1;
    logic [16:0] csum_fold2;
    logic [15:0] csum;

    assign out_free   = !out_valid_reg || m_tready;
    assign in_consume = in_valid_reg && !burst_active_reg && out_free;
    assign burst_emit = burst_active_reg && out_free;
    assign s_tready   = !in_valid_reg || in_consume;

    assign pos_adv = (pos_reg != POS_W'(MAX_FRAME_BYTES)) ? pos_reg + POS_W'(1) : pos_reg;

    assign total_len  = {hold_reg[16], hold_reg[17]} + 16'd20;
    assign csum_sum   = CSUM_BASE + {3'b000, total_len};
    assign csum_fold1 = {1'b0, csum_sum[15:0]} + {14'd0, csum_sum[18:16]};
    assign csum_fold2 = {1'b0, csum_fold1[15:0]} + {16'd0, csum_fold1[16]};
    assign csum       = ~csum_fold2[15:0];

    assign burst_end = burst_encap_reg ? ENCAP_BURST_LAST : PASS_BURST_LAST;

    // held byte for the current burst slot: the old mac header, then inner bytes 14..17
    always_comb begin
        if (!burst_encap_reg) begin
            hold_sel = burst_cnt_reg;
        end else if (burst_cnt_reg < BURST_W'(12)) begin
            hold_sel = burst_cnt_reg - BURST_W'(6);
        end else begin
            hold_sel = burst_cnt_reg - BURST_W'(20);
        end
    end
    assign hold_idx  = hold_sel[HOLD_IDX_W-1:0];
    assign hold_byte = hold_reg[hold_idx];

    always_comb begin
        if (!burst_encap_reg) begin
            burst_byte = hold_byte;
        end else begin
            case (burst_cnt_reg) inside
                [0:5], [26:33]:         burst_byte = 8'hFF;  // broadcast dst, addresses
                [6:11], [34:37]:        burst_byte = hold_byte;
                12, 22:                 burst_byte = 8'h08;  // ethertype hi, ttl
                14:                     burst_byte = 8'h45;  // version and ihl
                16:                     burst_byte = total_len[15:8];
                17:                     burst_byte = total_len[7:0];
                23:                     burst_byte = 8'h04;  // protocol ip-in-ip
                24:                     burst_byte = csum[15:8];
                25:                     burst_byte = csum[7:0];
                default:                burst_byte = 8'h00;  // ethertype lo, tos, id, frag
            endcase
        end
    end

    // protocol as seen including the current byte
    assign proto_now = (pos_reg == POS_PROTO) ? in_byte_reg : proto_reg;

    always_comb begin
        pos_next          = pos_reg;
        mode_next         = mode_reg;
        proto_next        = proto_reg;
        burst_active_next = burst_active_reg;
        burst_encap_next  = burst_encap_reg;
        burst_fin_next    = burst_fin_reg;
        burst_cnt_next    = burst_cnt_reg;
        hold_wr           = 1'b0;
        out_load          = 1'b0;
        ob                = 8'h00;
        ol                = 1'b0;
        ov                = VERDICT_TX;

        if (burst_emit) begin
            out_load = 1'b1;
            ob       = burst_byte;
            ol       = !burst_encap_reg && burst_fin_reg && (burst_cnt_reg == burst_end);
            ov       = ol ? VERDICT_PASS : VERDICT_TX;
            if (burst_cnt_reg == burst_end) begin
                burst_active_next = 1'b0;
            end else begin
                burst_cnt_next = burst_cnt_reg + BURST_W'(1);
            end
        end else if (in_consume) begin
            unique case (mode_reg)
                MODE_PASS: begin
                    out_load = 1'b1;
                    ob       = in_byte_reg;
                    ol       = in_last_reg;
                    ov       = in_last_reg ? VERDICT_PASS : VERDICT_TX;
                    pos_next = pos_adv;
                    if (in_last_reg) begin
                        pos_next   = '0;
                        mode_next  = MODE_COLLECT;
                        proto_next = 8'h00;
                    end
                end
                MODE_ENCAP: begin
                    out_load   = 1'b1;
                    ob         = in_byte_reg;
                    ol         = in_last_reg;
                    proto_next = proto_now;
                    pos_next   = pos_adv;
                    if (in_last_reg) begin
                        // frame length is position plus one
                        if (pos_reg < POS_W'(33)) begin
                            ov = VERDICT_DROP;
                        end else if (proto_now == PROTO_TCP && pos_reg < POS_W'(53)) begin
                            ov = VERDICT_DROP;
                        end else if (proto_now == PROTO_UDP && pos_reg < POS_W'(41)) begin
                            ov = VERDICT_DROP;
                        end
                        pos_next   = '0;
                        mode_next  = MODE_COLLECT;
                        proto_next = 8'h00;
                    end
                end
                default: begin
                    // collecting header, also the unused mode code
                    hold_wr = pos_reg < POS_W'(HOLD_BYTES);
                    if (pos_reg == POS_ETYPE_LO &&
                        !(hold_reg[12] == 8'h08 && in_byte_reg == 8'h00)) begin
                        burst_active_next = 1'b1;
                        burst_encap_next  = 1'b0;
                        burst_fin_next    = in_last_reg;
                        burst_cnt_next    = '0;
                        if (in_last_reg) begin
                            pos_next   = '0;
                            mode_next  = MODE_COLLECT;
                            proto_next = 8'h00;
                        end else begin
                            mode_next = MODE_PASS;
                            pos_next  = pos_adv;
                        end
                    end else if (in_last_reg) begin
                        // bare drop marker
                        out_load   = 1'b1;
                        ol         = 1'b1;
                        ov         = VERDICT_DROP;
                        pos_next   = '0;
                        mode_next  = MODE_COLLECT;
                        proto_next = 8'h00;
                    end else begin
                        if (pos_reg >= POS_HOLD_END) begin
                            burst_active_next = 1'b1;
                            burst_encap_next  = 1'b1;
                            burst_fin_next    = 1'b0;
                            burst_cnt_next    = '0;
                            mode_next         = MODE_ENCAP;
                        end
                        pos_next = pos_adv;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_reg          <= '0;
            mode_reg         <= MODE_COLLECT;
            proto_reg        <= 8'h00;
            burst_active_reg <= 1'b0;
            burst_encap_reg  <= 1'b0;
            burst_fin_reg    <= 1'b0;
            burst_cnt_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            pos_reg          <= pos_next;
            mode_reg         <= mode_next;
            proto_reg        <= proto_next;
            burst_active_reg <= burst_active_next;
            burst_encap_reg  <= burst_encap_next;
            burst_fin_reg    <= burst_fin_next;
            burst_cnt_reg    <= burst_cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load) begin
            out_byte_reg    <= ob;
            out_last_reg    <= ol;
            out_verdict_reg <= ov;
        end
        if (hold_wr) begin
            hold_reg[pos_reg[HOLD_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_verdict_reg;

    // a verdict other than transmit only rides on the last item of a frame
    `ASSERT_IMPL(a_verdict_on_last, m_tvalid && !m_tlast, m_tuser == VERDICT_TX,
                 "nonzero verdict on an item that is not last")
    // encapsulated streaming only starts once the whole held header is in
    `ASSERT_IMPL(a_encap_after_hold, in_consume && mode_reg == MODE_ENCAP,
                 pos_reg > POS_HOLD_END, "encap byte before the held header was emitted")
    // burst counter stays inside the burst that is playing
    `ASSERT_IMPL(a_burst_bound, burst_active_reg, burst_cnt_reg <= burst_end,
                 "burst counter ran past the end of its burst")

endmodule
